// File: sv/twqs_pkg.sv
// Package: shared types, codes and sizes for the thread wait queue scheduler.
`default_nettype none
package twqs_pkg;
    localparam int NumThreads = 16;
    localparam int NumWaitQueues = 8;
    localparam int NumQueues = NumWaitQueues + 1;
    localparam int ThrW = $clog2(NumThreads);
    localparam int QW = $clog2(NumQueues + 1);
    localparam int CntW = $clog2(NumThreads + 1);
    localparam logic [QW-1:0] RunQ = QW'(NumWaitQueues);
    localparam logic [QW-1:0] NoQ = QW'(NumWaitQueues + 1);

    typedef enum logic [2:0] {
        OP_SLEEP = 3'd0, OP_WAKEUP = 3'd1, OP_BROADCAST = 3'd2,
        OP_CANCEL = 3'd3, OP_MAKE_RUN = 3'd4, OP_SWITCH = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        RS_OK = 2'd0, RS_INTR = 2'd1, RS_EMPTY = 2'd2, RS_BAD = 2'd3
    } resp_t;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0, ST_RUN = 2'd1, ST_SLEEP = 2'd2, ST_SLEEPC = 2'd3
    } thr_state_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] wait_queue;
        logic [3:0] target_thread;
        logic       may_cancel;
    } request_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] chosen_thread;
        logic       chosen_valid;
        logic [4:0] moved_count;
        logic       chosen_cancelled;
    } result_t;

    // Controller to datapath commands
    typedef enum logic [2:0] {
        CMD_NOP    = 3'd0,
        CMD_PUSH   = 3'd1, // push thread cmd_thr onto queue cmd_q
        CMD_POP    = 3'd2, // pop head of cmd_q, remember it as popped thread
        CMD_RUNPOP = 3'd3, // push popped thread onto run queue
        CMD_UNLINK = 3'd4, // unlink cmd_thr from its own queue
        CMD_SETCUR = 3'd5  // current := popped thread (or none)
    } dp_op_t;

    typedef struct packed {
        dp_op_t         op;
        logic [QW-1:0]  q;
        logic [ThrW-1:0] thr;
        logic [1:0]     st;      // new state for pushed thread
        logic           set_cancel;
        logic           cur_none;
    } dp_cmd_t;

    typedef struct packed {
        logic            cur_valid;
        logic [ThrW-1:0] cur;
        logic            cur_free;   // current thread not on any queue
        logic            cur_cancel;
        logic            q_empty;    // selected queue empty
        logic            tg_free;
        logic            tg_sleepc;  // target sleeps cancellably on a wait queue
        logic [ThrW-1:0] popped;
        logic            popped_cancel;
    } dp_stat_t;
endpackage
`default_nettype wire

// File: sv/twqs_datapath.sv
// Datapath: per-thread tables, linked queues and current thread register.
`default_nettype none
module twqs_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire twqs_pkg::dp_cmd_t cmd,
    input  wire logic [twqs_pkg::QW-1:0]   sel_q,
    input  wire logic [twqs_pkg::ThrW-1:0] sel_thr,
    output twqs_pkg::dp_stat_t    stat
);
    import twqs_pkg::*;

    logic [1:0]      status_reg [NumThreads];
    logic            cancel_reg [NumThreads];
    logic [QW-1:0]   member_reg [NumThreads];
    logic [ThrW-1:0] next_reg   [NumThreads];
    logic [ThrW-1:0] prev_reg   [NumThreads];
    logic [ThrW-1:0] head_reg   [NumQueues];
    logic [ThrW-1:0] tail_reg   [NumQueues];
    logic [CntW-1:0] count_reg  [NumQueues];
    logic            cur_valid_reg;
    logic [ThrW-1:0] cur_reg;
    logic [ThrW-1:0] popped_reg;

    logic [ThrW-1:0] ut;      // thread being unlinked
    logic [QW-1:0]   uq;
    logic [ThrW-1:0] up, un;
    logic [ThrW-1:0] pt;      // thread being pushed
    logic [QW-1:0]   pq;
    logic [ThrW-1:0] pop_thr;

    // Status towards the controller
    always_comb
    begin
        stat.cur_valid     = cur_valid_reg;
        stat.cur           = cur_reg;
        stat.cur_free      = member_reg[cur_reg] == NoQ;
        stat.cur_cancel    = cancel_reg[cur_reg];
        stat.q_empty       = count_reg[sel_q[QW-1:0] < QW'(NumQueues) ?
                                       sel_q : RunQ] == '0;
        stat.tg_free       = member_reg[sel_thr] == NoQ;
        stat.tg_sleepc     = status_reg[sel_thr] == ST_SLEEPC &&
                             member_reg[sel_thr] < QW'(NumWaitQueues);
        stat.popped        = popped_reg;
        stat.popped_cancel = cancel_reg[popped_reg];
    end

    // Operand selection for unlink and push
    always_comb
    begin
        pop_thr = head_reg[cmd.q];
        ut = (cmd.op == CMD_POP) ? pop_thr : cmd.thr;
        uq = (cmd.op == CMD_POP) ? cmd.q : member_reg[cmd.thr];
        up = prev_reg[ut];
        un = next_reg[ut];
        pt = (cmd.op == CMD_RUNPOP) ? popped_reg : cmd.thr;
        pq = (cmd.op == CMD_RUNPOP) ? RunQ : cmd.q;
    end

    // Table updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumThreads; i++)
            begin
                status_reg[i] <= ST_NONE;
                cancel_reg[i] <= 1'b0;
                member_reg[i] <= NoQ;
            end
            for (int i = 0; i < NumQueues; i++)
            begin
                count_reg[i] <= '0;
            end
            cur_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_cancel)
            begin
                cancel_reg[cmd.thr] <= 1'b1;
            end
            case (cmd.op)
                CMD_PUSH, CMD_RUNPOP:
                begin
                    if (count_reg[pq] == '0)
                    begin
                        head_reg[pq] <= pt;
                    end
                    else
                    begin
                        next_reg[tail_reg[pq]] <= pt;
                        prev_reg[pt] <= tail_reg[pq];
                    end
                    tail_reg[pq]   <= pt;
                    count_reg[pq]  <= count_reg[pq] + 1'b1;
                    member_reg[pt] <= pq;
                    status_reg[pt] <= (cmd.op == CMD_RUNPOP) ? ST_RUN : cmd.st;
                end
                CMD_POP, CMD_UNLINK:
                begin
                    if (head_reg[uq] == ut)
                        head_reg[uq] <= un;
                    else
                        next_reg[up] <= un;
                    if (tail_reg[uq] == ut)
                        tail_reg[uq] <= up;
                    else
                        prev_reg[un] <= up;
                    count_reg[uq]  <= count_reg[uq] - 1'b1;
                    member_reg[ut] <= NoQ;
                    popped_reg     <= ut;
                end
                CMD_SETCUR:
                begin
                    cur_valid_reg <= !cmd.cur_none;
                    cur_reg       <= popped_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pops only touch non-empty queues, unlinks only threads on a wait queue, pushes only unqueued threads
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_POP) |-> count_reg[cmd.q] != '0)
        else $error("pop of empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_UNLINK) |-> member_reg[cmd.thr] < QW'(NumWaitQueues))
        else $error("unlink of thread not on a wait queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == CMD_PUSH) |-> member_reg[cmd.thr] == NoQ)
        else $error("push of queued thread");
endmodule
`default_nettype wire

// File: sv/twqs_ctrl.sv
// Controller: sequences each request into datapath commands and forms the result.
`default_nettype none
module twqs_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire twqs_pkg::request_t  req,
    output logic                     busy,
    output logic                     done,
    output twqs_pkg::result_t        result,
    output twqs_pkg::dp_cmd_t        cmd,
    output logic [twqs_pkg::QW-1:0]  sel_q,
    output logic [twqs_pkg::ThrW-1:0] sel_thr,
    input  wire twqs_pkg::dp_stat_t  stat
);
    import twqs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DEC   = 6'b000010,
        S_POP   = 6'b000100,
        S_RUN   = 6'b001000,
        S_CUR   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    request_t        req_reg;
    result_t         res_reg, res_next;
    logic [QW-1:0]   popq_reg, popq_next;
    logic            bcast_reg, bcast_next;
    logic            done_reg, done_next;
    logic            wq_ok;

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = res_reg;
    assign wq_ok  = {1'b0, req_reg.wait_queue} < 4'(NumWaitQueues);
    assign sel_thr = req_reg.target_thread;

    // Queue whose emptiness matters in the current state
    always_comb
    begin
        if (state_reg == S_DEC)
            sel_q = (req_reg.opcode == OP_SWITCH) ? RunQ : QW'(req_reg.wait_queue);
        else
            sel_q = popq_reg;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        popq_next  = popq_reg;
        bcast_next = bcast_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.op     = CMD_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                res_next   = '0;
                state_next = S_DONE;
                bcast_next = 1'b0;
                case (req_reg.opcode)
                    OP_SLEEP:
                    begin
                        if (!wq_ok || !stat.cur_valid || !stat.cur_free)
                            res_next.status = RS_BAD;
                        else if (req_reg.may_cancel && stat.cur_cancel)
                            res_next.status = RS_INTR;
                        else
                        begin
                            cmd.op  = CMD_PUSH;
                            cmd.q   = QW'(req_reg.wait_queue);
                            cmd.thr = stat.cur;
                            cmd.st  = req_reg.may_cancel ? ST_SLEEPC : ST_SLEEP;
                            popq_next  = RunQ;
                            state_next = S_POP;
                        end
                    end
                    OP_WAKEUP, OP_BROADCAST:
                    begin
                        if (!wq_ok)
                            res_next.status = RS_BAD;
                        else if (stat.q_empty)
                            res_next.status = (req_reg.opcode == OP_WAKEUP) ?
                                              RS_EMPTY : RS_OK;
                        else
                        begin
                            popq_next  = QW'(req_reg.wait_queue);
                            bcast_next = req_reg.opcode == OP_BROADCAST;
                            state_next = S_POP;
                        end
                    end
                    OP_CANCEL:
                    begin
                        cmd.thr        = req_reg.target_thread;
                        cmd.set_cancel = 1'b1;
                        if (stat.tg_sleepc)
                        begin
                            cmd.op = CMD_UNLINK;
                            res_next.chosen_thread = req_reg.target_thread;
                            res_next.chosen_valid  = 1'b1;
                            res_next.moved_count   = 5'd1;
                            state_next = S_RUN;
                        end
                    end
                    OP_MAKE_RUN:
                    begin
                        if (!stat.tg_free)
                            res_next.status = RS_BAD;
                        else
                        begin
                            cmd.op  = CMD_PUSH;
                            cmd.q   = RunQ;
                            cmd.thr = req_reg.target_thread;
                            cmd.st  = ST_RUN;
                            res_next.chosen_thread = req_reg.target_thread;
                            res_next.chosen_valid  = 1'b1;
                            res_next.moved_count   = 5'd1;
                        end
                    end
                    OP_SWITCH:
                    begin
                        popq_next = RunQ;
                        if (stat.q_empty)
                            res_next.status = RS_EMPTY;
                        else
                            state_next = S_POP;
                    end
                    default:
                    begin
                        res_next.status = RS_BAD;
                    end
                endcase
            end
            S_POP:
            begin
                // After a sleep push the run queue may still be empty
                if (stat.q_empty)
                begin
                    cmd.op       = CMD_SETCUR;
                    cmd.cur_none = 1'b1;
                    res_next.status = RS_EMPTY;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = CMD_POP;
                    cmd.q  = popq_reg;
                    state_next = (popq_reg == RunQ) ? S_CUR : S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.op = CMD_RUNPOP;
                if (req_reg.opcode != OP_CANCEL)
                begin
                    res_next.moved_count = res_reg.moved_count + 5'd1;
                    if (!bcast_reg)
                    begin
                        res_next.chosen_thread = stat.popped;
                        res_next.chosen_valid  = 1'b1;
                    end
                end
                state_next = bcast_reg ? S_POP : S_DONE;
                if (bcast_reg && stat.q_empty)
                    state_next = S_DONE;
            end
            S_CUR:
            begin
                cmd.op = CMD_SETCUR;
                res_next.chosen_thread    = stat.popped;
                res_next.chosen_valid     = 1'b1;
                res_next.chosen_cancelled = stat.popped_cancel;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            bcast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            bcast_reg <= bcast_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            req_reg <= req;
        res_reg  <= res_next;
        popq_reg <= popq_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> done && state_reg == S_IDLE)
        else $error("result strobe missing");
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("strobe while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request not taken");
endmodule
`default_nettype wire

// File: sv/thread_wait_queue_scheduler.sv
// Top level: thread scheduler with a FIFO run queue and FIFO wait queues.
//
//  channel  | ports                   | handshake
//  ---------+-------------------------+----------------------------------
//  request  | start, busy, req        | taken when start && !busy
//  result   | done, result            | one-cycle strobe, cannot be held
//
// Every request passes through decode and the done state; sleep, switch, wakeup and
// a cancel that wakes a thread add pop, run-queue or current-thread steps, and a
// broadcast pops and re-pushes each thread that it moves: the controller issues
// one queue update per cycle on the shared link tables.
// busy is high from acceptance until the result strobe.
// rst_n clears all thread states, cancel flags, queue counts and current thread.
`default_nettype none
module thread_wait_queue_scheduler (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire twqs_pkg::request_t req,
    output logic                    busy,
    output logic                    done,
    output twqs_pkg::result_t       result
);
    import twqs_pkg::*;

    dp_cmd_t         cmd;
    dp_stat_t        stat;
    logic [QW-1:0]   sel_q;
    logic [ThrW-1:0] sel_thr;

    twqs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .cmd     (cmd),
        .sel_q   (sel_q),
        .sel_thr (sel_thr),
        .stat    (stat)
    );

    twqs_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sel_q   (sel_q),
        .sel_thr (sel_thr),
        .stat    (stat)
    );
endmodule
`default_nettype wire
